>>> rtl/mbem_pkg.sv
// mbem_pkg: shared constants, types and crc helper of the energy meter responder
// used by mbem_ctrl, mbem_dpath and modbus_energy_meter_responder
// no dependencies
`timescale 1ns / 1ps

package mbem_pkg;

  // input item kinds carried on in_tuser
  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_SEED    = 2'd2;

  // protocol constants
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [7:0]  REPLY_DATA_LEN  = 8'h14;
  localparam logic [4:0]  REPLY_LAST_IDX  = 5'd24;
  localparam logic [2:0]  REQ_LAST_IDX    = 3'd7;
  localparam logic [2:0]  REQ_CRC_LAST    = 3'd5;

  // energy integration
  localparam logic [27:0] MWS_PER_WH     = 28'd3600000;
  localparam logic [31:0] ENERGY_SEED_RST = 32'd100;

  // field widths of the input item
  localparam int VOLT_W = 12;
  localparam int CURR_W = 17;
  localparam int PWR_W  = 20;
  localparam int FREQ_W = 10;
  localparam int PF_W   = 7;
  localparam int IN_DATA_W = 80;

  // commands from controller to datapath
  typedef struct packed {
    logic rx_en;
    logic tick_en;
    logic seed_en;
    logic acc_load;
    logic div_step;
    logic div_finish;
    logic reply_start;
    logic reply_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_req_byte;
    logic frame_ok;
    logic div_more;
    logic reply_last;
    logic out_free;
  } status_t;

  // one byte of reflected crc-16, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/mbem_ctrl.sv
// mbem_ctrl: sequencing state machine of the energy meter responder
// depends on mbem_pkg (cmd_t, status_t, opcodes)
`timescale 1ns / 1ps

module mbem_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [1:0]       in_opcode,
  output logic             in_tready,
  input  mbem_pkg::status_t st,
  output mbem_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ACC   = 5'b00010,
    S_DIV   = 5'b00100,
    S_CHECK = 5'b01000,
    S_REPLY = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_opcode)
            mbem_pkg::OP_RX_BYTE: begin
              cmd.rx_en = 1'b1;
              if (st.last_req_byte) state_nxt = S_CHECK;
            end
            mbem_pkg::OP_TICK: begin
              cmd.tick_en = 1'b1;
              state_nxt   = S_ACC;
            end
            mbem_pkg::OP_SEED: begin
              cmd.seed_en = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_ACC: begin
        cmd.acc_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (st.div_more) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.div_finish = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_CHECK: begin
        if (st.frame_ok) begin
          cmd.reply_start = 1'b1;
          state_nxt       = S_REPLY;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_REPLY: begin
        if (st.out_free) begin
          cmd.reply_load = 1'b1;
          if (st.reply_last) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/mbem_dpath.sv
// mbem_dpath: request buffer, crc units, energy integrator and reply serializer
// depends on mbem_pkg (cmd_t, status_t, crc16_byte, constants)
`timescale 1ns / 1ps

module mbem_dpath (
  input  logic             clk,
  input  logic             rst_n,
  input  mbem_pkg::cmd_t   cmd,
  output mbem_pkg::status_t st,
  input  logic [7:0]       rx_byte,
  input  logic [mbem_pkg::VOLT_W-1:0] voltage_raw,
  input  logic [mbem_pkg::CURR_W-1:0] current_raw,
  input  logic [mbem_pkg::PWR_W-1:0]  power_raw,
  input  logic [mbem_pkg::FREQ_W-1:0] frequency_raw,
  input  logic [mbem_pkg::PF_W-1:0]   pf_raw,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_last,
  input  logic             out_ready
);

  // request buffer and receive side
  logic [7:0]  req_r [8];
  logic [2:0]  cnt_r;
  logic [15:0] rcrc_r;
  logic [15:0] rcrc_base;

  // snapshot of the measurement fields for the reply
  logic [mbem_pkg::VOLT_W-1:0] volt_r;
  logic [mbem_pkg::CURR_W-1:0] curr_r;
  logic [mbem_pkg::PWR_W-1:0]  pwr_r;
  logic [mbem_pkg::FREQ_W-1:0] freq_r;
  logic [mbem_pkg::PF_W-1:0]   pf_r;

  // energy integrator
  logic [26:0] prod_r;
  logic [27:0] acc_r;
  logic [21:0] frac_r;
  logic [31:0] wh_r;
  logic [31:0] seed_r;

  // reply serializer
  logic [4:0]  idx_r;
  logic [15:0] tcrc_r;
  logic [7:0]  reply_byte;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= mbem_pkg::ENERGY_SEED_RST;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // request collection with running crc over the first six bytes
  assign rcrc_base = (cnt_r == 3'd0) ? mbem_pkg::CRC_INIT : rcrc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (cmd.rx_en) begin
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rx_en) begin
      req_r[cnt_r] <= rx_byte;
      volt_r       <= voltage_raw;
      curr_r       <= current_raw;
      pwr_r        <= power_raw;
      freq_r       <= frequency_raw;
      pf_r         <= pf_raw;
      if (cnt_r <= mbem_pkg::REQ_CRC_LAST) begin
        rcrc_r <= mbem_pkg::crc16_byte(rcrc_base, rx_byte);
      end
    end
  end

  // request check
  assign st.last_req_byte = (cnt_r == mbem_pkg::REQ_LAST_IDX);
  assign st.frame_ok = (rcrc_r == {req_r[7], req_r[6]}) &&
                       (req_r[1] == mbem_pkg::FUNC_READ_INPUT) &&
                       (req_r[2] == 8'h00) && (req_r[3] == 8'h00);

  // product register, then fraction add, then one whole Wh per cycle
  always_ff @(posedge clk) begin
    if (cmd.tick_en) begin
      prod_r <= 27'(power_raw * pf_raw);
    end
    if (cmd.acc_load) begin
      acc_r <= 28'(frac_r) + 28'(prod_r);
    end else if (cmd.div_step) begin
      acc_r <= acc_r - mbem_pkg::MWS_PER_WH;
    end
  end

  assign st.div_more = (acc_r >= mbem_pkg::MWS_PER_WH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wh_r   <= 32'd0;
      frac_r <= 22'd0;
    end else if (cmd.seed_en) begin
      wh_r   <= seed_r;
      frac_r <= 22'd0;
    end else if (cmd.div_step) begin
      if (wh_r != 32'hFFFF_FFFF) wh_r <= wh_r + 32'd1;
    end else if (cmd.div_finish) begin
      frac_r <= acc_r[21:0];
    end
  end

  // reply byte selection
  always_comb begin
    case (idx_r)
      5'd0:    reply_byte = req_r[0];
      5'd1:    reply_byte = mbem_pkg::FUNC_READ_INPUT;
      5'd2:    reply_byte = mbem_pkg::REPLY_DATA_LEN;
      5'd3:    reply_byte = {4'd0, volt_r[11:8]};
      5'd4:    reply_byte = volt_r[7:0];
      5'd5:    reply_byte = curr_r[15:8];
      5'd6:    reply_byte = curr_r[7:0];
      5'd7:    reply_byte = 8'h00;
      5'd8:    reply_byte = {7'd0, curr_r[16]};
      5'd9:    reply_byte = pwr_r[15:8];
      5'd10:   reply_byte = pwr_r[7:0];
      5'd11:   reply_byte = 8'h00;
      5'd12:   reply_byte = {4'd0, pwr_r[19:16]};
      5'd13:   reply_byte = wh_r[15:8];
      5'd14:   reply_byte = wh_r[7:0];
      5'd15:   reply_byte = wh_r[31:24];
      5'd16:   reply_byte = wh_r[23:16];
      5'd17:   reply_byte = {6'd0, freq_r[9:8]};
      5'd18:   reply_byte = freq_r[7:0];
      5'd19:   reply_byte = 8'h00;
      5'd20:   reply_byte = {1'b0, pf_r};
      5'd23:   reply_byte = tcrc_r[7:0];
      5'd24:   reply_byte = tcrc_r[15:8];
      default: reply_byte = 8'h00;
    endcase
  end

  // reply index, updated as each byte is loaded, and transmit crc over the bytes before the crc field
  always_ff @(posedge clk) begin
    if (cmd.reply_start) begin
      idx_r  <= 5'd0;
      tcrc_r <= mbem_pkg::CRC_INIT;
    end else if (cmd.reply_load) begin
      idx_r <= idx_r + 5'd1;
      if (idx_r < 5'd23) tcrc_r <= mbem_pkg::crc16_byte(tcrc_r, reply_byte);
    end
  end

  assign st.reply_last = (idx_r == mbem_pkg::REPLY_LAST_IDX);
  assign st.out_free   = !out_valid_r || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.reply_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply_load) begin
      out_byte_r <= reply_byte;
      out_last_r <= (idx_r == mbem_pkg::REPLY_LAST_IDX);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

>>> rtl/modbus_energy_meter_responder.sv
// modbus_energy_meter_responder: top level of the read-input-registers slave
// depends on mbem_pkg, mbem_ctrl and mbem_dpath
//
//   channel  dir  handshake          payload
//   in_      in   tvalid / tready    tuser: opcode, tdata: measurements and rx byte
//   out_     out  tvalid / tready    tdata: tx_byte, tlast: last_byte
//   cfg_     in   wr_en              wr_data: initial_energy_wh
//
// a received byte or a seed is taken in idle; the eighth request byte leads to
// a crc and header check, then the reply loads one byte per cycle, 25 bytes,
// unless out_tready stalls it; a tick registers the product, adds the fraction
// and then adds one whole Wh per step of a subtract loop on 3600000
// in_tready is low while a check, an integration or a reply is in progress
// a stalled out_tready holds the reply byte; synchronous active-low reset
`timescale 1ns / 1ps

module modbus_energy_meter_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // rx_byte[7:0], voltage_raw[19:8], current_raw[36:20], power_raw[56:37],
  // frequency_raw[66:57], pf_raw[73:67], zero fill[79:74]
  input  logic [79:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tx_byte[7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  mbem_pkg::cmd_t    cmd;
  mbem_pkg::status_t st;

  // controller
  mbem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_opcode (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath
  mbem_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .rx_byte       (in_tdata[7:0]),
    .voltage_raw   (in_tdata[19:8]),
    .current_raw   (in_tdata[36:20]),
    .power_raw     (in_tdata[56:37]),
    .frequency_raw (in_tdata[66:57]),
    .pf_raw        (in_tdata[73:67]),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_tvalid),
    .out_byte      (out_tdata),
    .out_last      (out_tlast),
    .out_ready     (out_tready)
  );

endmodule

>>> rtl/mbem_checker.sv
// mbem_checker: port-level checks of the energy meter responder, bound to the top
// depends on mbem_pkg (opcodes) and modbus_energy_meter_responder
`timescale 1ns / 1ps

module mbem_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // a stalled reply byte holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("reply byte changed while stalled");

  // no new request while a reply is still being serialized
  a_reply_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken in the middle of a reply");

  // an accepted tick starts the integrator and closes the input
  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == mbem_pkg::OP_TICK) |=> !in_tready)
    else $error("input open right after a tick");

endmodule

bind modbus_energy_meter_responder mbem_checker u_mbem_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
